// File: rtl/core/fqkd_pkg.sv
// Shared sizes, operation codes and cell control type for the keyed-delete record queue.
`timescale 1ns / 1ps
package fqkd_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_BITS  = 48;
  localparam int DATA_BITS = 32;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;
  localparam logic [1:0] OP_SRC = 2'd3;

  typedef struct packed {
    logic match_ld;
    logic prop;
    logic deq;
    logic del;
  } cell_ctl_t;

endpackage

// File: rtl/core/fqkd_cell.sv
// One queue slot: holds a record, compares it against a key and ripples the earlier-hit flag.
`timescale 1ns / 1ps
module fqkd_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fqkd_pkg::cell_ctl_t           ctl_i,
  input  logic                          write_i,
  input  logic                          in_use_i,
  input  logic [fqkd_pkg::KEY_BITS-1:0]  key_i,
  input  logic [fqkd_pkg::DATA_BITS-1:0] data_i,
  input  logic [fqkd_pkg::KEY_BITS-1:0]  nxt_key_i,
  input  logic [fqkd_pkg::DATA_BITS-1:0] nxt_data_i,
  input  logic                          carry_i,
  output logic [fqkd_pkg::KEY_BITS-1:0]  key_o,
  output logic [fqkd_pkg::DATA_BITS-1:0] data_o,
  output logic                          carry_o,
  output logic                          first_o
);
  import fqkd_pkg::*;

  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] data_q;
  logic                 match_q;
  logic                 carry_q;

  assign key_o   = key_q;
  assign data_o  = data_q;
  assign carry_o = carry_q | match_q;
  assign first_o = match_q & ~carry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      carry_q <= 1'b0;
    end else if (ctl_i.match_ld) begin
      match_q <= in_use_i && (key_i == key_q);
      carry_q <= 1'b0;
    end else if (ctl_i.prop) begin
      carry_q <= carry_i;
    end
  end

  // slots at or after the first hit close the gap on delete
  always_ff @(posedge clk_i) begin
    if (write_i) begin
      key_q  <= key_i;
      data_q <= data_i;
    end else if (ctl_i.deq || (ctl_i.del && carry_o)) begin
      key_q  <= nxt_key_i;
      data_q <= nxt_data_i;
    end
  end

endmodule

// File: rtl/core/fifo_queue_with_keyed_delete.sv
// Top level of the record queue with enqueue, dequeue, delete by key and search by key.
//
//  channel   signals                                         direction
//  command   start, busy, op_i, entry_key_i, entry_data_i     in (busy out)
//  result    result_valid_o, success_o, out_key_o, out_data_o,
//            position_o, now_empty_o, occupancy_o             out
//
// Enqueue and dequeue finish at the accepting edge; the result beat follows in the next cycle
// and busy stays low, so they may be issued every cycle.
// Delete and search scan before the result beat: the earlier-hit flag ripples one cell per cycle
// through the cells (S_SCAN), then the hit is gathered (S_FIN). busy is high while they run.
// Reset empties the queue; slot contents are left as they are.
// The receiver cannot stall: each result beat is shown for one cycle only.
`timescale 1ns / 1ps
module fifo_queue_with_keyed_delete (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op_i,
  input  logic [fqkd_pkg::KEY_BITS-1:0]  entry_key_i,
  input  logic [fqkd_pkg::DATA_BITS-1:0] entry_data_i,
  output logic                          result_valid_o,
  output logic                          success_o,
  output logic [fqkd_pkg::KEY_BITS-1:0]  out_key_o,
  output logic [fqkd_pkg::DATA_BITS-1:0] out_data_o,
  output logic [fqkd_pkg::IDX_BITS-1:0]  position_o,
  output logic                          now_empty_o,
  output logic [fqkd_pkg::CNT_BITS-1:0]  occupancy_o
);
  import fqkd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [IDX_BITS-1:0] step_q, step_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                del_q, del_d;

  logic                 valid_q, valid_d;
  logic                 ok_q, ok_d;
  logic [KEY_BITS-1:0]  rkey_q, rkey_d;
  logic [DATA_BITS-1:0] rdata_q, rdata_d;
  logic [IDX_BITS-1:0]  pos_q, pos_d;

  logic                 accept;
  cell_ctl_t            ctl;
  logic [DEPTH-1:0]     in_use;
  logic [DEPTH-1:0]     wr;
  logic [DEPTH-1:0]     first;
  logic [DEPTH-1:0]     carry;
  logic [KEY_BITS-1:0]  cell_key  [DEPTH];
  logic [DATA_BITS-1:0] cell_data [DEPTH];
  logic [KEY_BITS-1:0]  hit_key;
  logic [DATA_BITS-1:0] hit_data;
  logic [IDX_BITS-1:0]  hit_pos;
  logic                 found;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    ctl.match_ld = accept && ((op_i == OP_DEL) || (op_i == OP_SRC));
    ctl.prop     = (state_q == S_SCAN);
    ctl.deq      = accept && (op_i == OP_DEQ) && (count_q != '0);
    ctl.del      = (state_q == S_FIN) && del_q;
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      in_use[i] = CNT_BITS'(i) < count_q;
      wr[i]     = accept && (op_i == OP_ENQ) && (CNT_BITS'(i) == count_q);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0]  nkey;
    logic [DATA_BITS-1:0] ndata;
    logic                 cin;
    if (g == DEPTH - 1) begin : g_last
      assign nkey  = cell_key[g];
      assign ndata = cell_data[g];
    end else begin : g_mid
      assign nkey  = cell_key[g+1];
      assign ndata = cell_data[g+1];
    end
    if (g == 0) begin : g_head
      assign cin = 1'b0;
    end else begin : g_body
      assign cin = carry[g-1];
    end
    fqkd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .write_i    (wr[g]),
      .in_use_i   (in_use[g]),
      .key_i      (entry_key_i),
      .data_i     (entry_data_i),
      .nxt_key_i  (nkey),
      .nxt_data_i (ndata),
      .carry_i    (cin),
      .key_o      (cell_key[g]),
      .data_o     (cell_data[g]),
      .carry_o    (carry[g]),
      .first_o    (first[g])
    );
  end

  // at most one cell flags first hit, so an OR gathers it
  always_comb begin
    hit_key  = '0;
    hit_data = '0;
    hit_pos  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        hit_key  = hit_key | cell_key[i];
        hit_data = hit_data | cell_data[i];
        hit_pos  = hit_pos | IDX_BITS'(i);
      end
    end
    found = |first;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    count_d = count_q;
    del_d   = del_q;
    valid_d = 1'b0;
    ok_d    = ok_q;
    rkey_d  = rkey_q;
    rdata_d = rdata_q;
    pos_d   = pos_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ok_d    = 1'b0;
          rkey_d  = '0;
          rdata_d = '0;
          pos_d   = '0;
          case (op_i)
            OP_ENQ: begin
              valid_d = 1'b1;
              if (count_q != CNT_BITS'(DEPTH)) begin
                ok_d    = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            OP_DEQ: begin
              valid_d = 1'b1;
              if (count_q != '0) begin
                ok_d    = 1'b1;
                rkey_d  = cell_key[0];
                rdata_d = cell_data[0];
                count_d = count_q - 1'b1;
              end
            end
            default: begin
              del_d   = (op_i == OP_DEL);
              step_d  = '0;
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        step_d = step_q + 1'b1;
        if (step_q == IDX_BITS'(DEPTH - 2)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        valid_d = 1'b1;
        ok_d    = found;
        rkey_d  = hit_key;
        rdata_d = hit_data;
        pos_d   = hit_pos;
        if (del_q && found) begin
          count_d = count_q - 1'b1;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      count_q <= '0;
      del_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      del_q   <= del_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q    <= ok_d;
    rkey_q  <= rkey_d;
    rdata_q <= rdata_d;
    pos_q   <= pos_d;
  end

  assign result_valid_o = valid_q;
  assign success_o      = ok_q;
  assign out_key_o      = rkey_q;
  assign out_data_o     = rdata_q;
  assign position_o     = pos_q;
  assign now_empty_o    = (count_q == '0);
  assign occupancy_o    = count_q;

endmodule

// File: sim/tb.sv
// Self-checking bench for the keyed-delete record queue: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;
  import fqkd_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int POOL_SIZE    = 16;

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [DATA_BITS-1:0] data_t;

  typedef struct packed {
    logic                success;
    key_t                rec_key;
    data_t               rec_data;
    logic [IDX_BITS-1:0] position;
    logic                empty;
    logic [CNT_BITS-1:0] count;
  } outcome_t;

  typedef struct packed {
    key_t  rec_key;
    data_t rec_data;
  } record_t;

  typedef struct {
    logic [1:0] op;
    key_t       key;
    data_t      data;
    bit         pinned;
    outcome_t   golden;
  } row_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start        = 1'b0;
  logic [1:0]          op_i         = OP_ENQ;
  key_t                entry_key_i  = '0;
  data_t               entry_data_i = '0;
  logic                busy;
  logic                result_valid_o;
  logic                success_o;
  key_t                out_key_o;
  data_t               out_data_o;
  logic [IDX_BITS-1:0] position_o;
  logic                now_empty_o;
  logic [CNT_BITS-1:0] occupancy_o;

  // typed expectation travelling with the beat on the command side
  bit       row_pinned = 1'b0;
  outcome_t row_golden = '0;

  record_t  held_records[$];
  outcome_t pending_outcomes[$];
  row_t     plan[$];
  key_t     key_pool[POOL_SIZE];
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  int       burst_left     = 0;

  fifo_queue_with_keyed_delete dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .entry_key_i   (entry_key_i),
    .entry_data_i  (entry_data_i),
    .result_valid_o(result_valid_o),
    .success_o     (success_o),
    .out_key_o     (out_key_o),
    .out_data_o    (out_data_o),
    .position_o    (position_o),
    .now_empty_o   (now_empty_o),
    .occupancy_o   (occupancy_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic outcome_t apply_command(logic [1:0] op, key_t key, data_t data);
    outcome_t res;
    record_t  rec;
    int       hit;
    res = '0;
    hit = -1;
    if (op == OP_DEL || op == OP_SRC) begin
      foreach (held_records[i]) if (hit < 0 && held_records[i].rec_key == key) hit = i;
    end
    case (op)
      OP_ENQ: if (held_records.size() < DEPTH) begin
        rec.rec_key  = key;
        rec.rec_data = data;
        held_records.push_back(rec);
        res.success = 1'b1;
      end
      OP_DEQ: if (held_records.size() > 0) begin
        rec = held_records.pop_front();
        res.success  = 1'b1;
        res.rec_key  = rec.rec_key;
        res.rec_data = rec.rec_data;
      end
      default: if (hit >= 0) begin
        res.success  = 1'b1;
        res.rec_key  = held_records[hit].rec_key;
        res.rec_data = held_records[hit].rec_data;
        res.position = IDX_BITS'(hit);
        if (op == OP_DEL) held_records.delete(hit);
      end
    endcase
    res.empty = (held_records.size() == 0);
    res.count = CNT_BITS'(held_records.size());
    return res;
  endfunction

  function automatic outcome_t outcome(bit ok, key_t key, data_t data, int pos, int n);
    outcome_t res;
    res.success  = ok;
    res.rec_key  = key;
    res.rec_data = data;
    res.position = IDX_BITS'(pos);
    res.empty    = (n == 0);
    res.count    = CNT_BITS'(n);
    return res;
  endfunction

  function automatic void add_row(logic [1:0] op, key_t key, data_t data, bit pinned,
                                  outcome_t golden);
    row_t r;
    r.op     = op;
    r.key    = key;
    r.data   = data;
    r.pinned = pinned;
    r.golden = golden;
    plan.push_back(r);
  endfunction

  function automatic key_t bcd_key();
    key_t k;
    for (int d = 0; d < KEY_BITS / 4; d++) k[4*d +: 4] = 4'($urandom_range(9));
    return k;
  endfunction

  function automatic key_t wild_key();
    return key_t'({$urandom, $urandom});
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : beat_monitor
    outcome_t got;
    outcome_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        got = '{success_o, out_key_o, out_data_o, position_o, now_empty_o, occupancy_o};
        if (pending_outcomes.size() == 0) begin
          report_mismatch("unrequested beat", 64'(got.rec_key), 64'(0));
        end else begin
          want = pending_outcomes.pop_front();
          if (got.success !== want.success)
            report_mismatch("success", 64'(got.success), 64'(want.success));
          if (got.rec_key !== want.rec_key)
            report_mismatch("out_key", 64'(got.rec_key), 64'(want.rec_key));
          if (got.rec_data !== want.rec_data)
            report_mismatch("out_data", 64'(got.rec_data), 64'(want.rec_data));
          if (got.position !== want.position)
            report_mismatch("position", 64'(got.position), 64'(want.position));
          if (got.empty !== want.empty)
            report_mismatch("now_empty", 64'(got.empty), 64'(want.empty));
          if (got.count !== want.count)
            report_mismatch("occupancy", 64'(got.count), 64'(want.count));
        end
      end
      if (start && !busy) begin
        want = apply_command(op_i, entry_key_i, entry_data_i);
        if (row_pinned) want = row_golden;
        pending_outcomes.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fifo_queue_with_keyed_delete regression: fail");
      $finish;
    end
  end

  task automatic issue(logic [1:0] op, key_t key, data_t data, bit pinned, outcome_t golden);
    start        <= 1'b1;
    op_i         <= op;
    entry_key_i  <= key;
    entry_data_i <= data;
    row_pinned   <= pinned;
    row_golden   <= golden;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // called once the command is accepted and busy is low; keeps the burst going, idles, or drains
  task automatic pace(bit drain);
    int gap;
    gap = 0;
    if (drain || burst_left == 0) begin
      start        <= 1'b0;
      op_i         <= 2'($urandom_range(3));
      entry_key_i  <= wild_key();
      entry_data_i <= $urandom;
      row_pinned   <= 1'b0;
      gap        = $urandom_range(1, 20);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
    if (drain) begin
      do @(posedge clk_i); while (pending_outcomes.size() != 0);
    end else begin
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    int         enq_pct;
    int         roll;
    logic [1:0] op;
    key_t       key;
    data_t      data;
    key_t       tail_key;

    foreach (key_pool[i]) key_pool[i] = bcd_key();
    key_pool[0] = '0;
    key_pool[1] = '1;

    add_row(OP_DEQ, '0, '1, 1'b1, outcome(0, '0, '0, 0, 0));
    add_row(OP_SRC, '1, '0, 1'b1, outcome(0, '0, '0, 0, 0));
    add_row(OP_DEL, '0, '0, 1'b1, outcome(0, '0, '0, 0, 0));
    add_row(OP_ENQ, '0, '0, 1'b1, outcome(1, '0, '0, 0, 1));
    add_row(OP_ENQ, '1, '1, 1'b1, outcome(1, '0, '0, 0, 2));
    add_row(OP_ENQ, '0, 32'hA5A5_5A5A, 1'b1, outcome(1, '0, '0, 0, 3));
    tail_key = '0;
    for (int n = 4; n <= DEPTH; n++) begin
      tail_key = bcd_key();
      add_row(OP_ENQ, tail_key, $urandom, 1'b1, outcome(1, '0, '0, 0, n));
    end
    // full: refused
    add_row(OP_ENQ, 48'h9999_9999_9999, '1, 1'b1, outcome(0, '0, '0, 0, DEPTH));
    add_row(OP_SRC, '1, '0, 1'b1, outcome(1, '1, '1, 1, DEPTH));
    add_row(OP_SRC, 48'hABCD_EF00_0000, '0, 1'b1, outcome(0, '0, '0, 0, DEPTH));
    // duplicate key: the one nearest the head goes
    add_row(OP_DEL, '0, '1, 1'b1, outcome(1, '0, '0, 0, DEPTH - 1));
    add_row(OP_SRC, '0, '0, 1'b1, outcome(1, '0, 32'hA5A5_5A5A, 1, DEPTH - 1));
    add_row(OP_DEL, 48'hABCD_EF00_0000, '0, 1'b1, outcome(0, '0, '0, 0, DEPTH - 1));
    add_row(OP_DEL, tail_key, '0, 1'b0, '0);
    add_row(OP_DEQ, '0, '0, 1'b1, outcome(1, '1, '1, 0, DEPTH - 3));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      issue(plan[i].op, plan[i].key, plan[i].data, plan[i].pinned, plan[i].golden);
      pace(1'b0);
    end

    enq_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(3))
          0: enq_pct = 15;
          1: enq_pct = 35;
          2: enq_pct = 50;
          default: enq_pct = 75;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < enq_pct) begin
        op = OP_ENQ;
      end else begin
        case ($urandom_range(2))
          0: op = OP_DEQ;
          1: op = OP_DEL;
          default: op = OP_SRC;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 10 && held_records.size() > 0 && op != OP_ENQ)
        key = held_records[$urandom_range(held_records.size() - 1)].rec_key;
      else if (roll < 82)
        key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else
        key = wild_key();
      data = $urandom;
      issue(op, key, data, 1'b0, '0);
      pace(i == RANDOM_ITEMS / 2 || i == RANDOM_ITEMS - 1);
    end

    repeat (DEPTH + 4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("fifo_queue_with_keyed_delete regression: pass");
    end else begin
      $display("fifo_queue_with_keyed_delete regression: fail");
    end
    $finish;
  end

endmodule

// File: fifo_queue_with_keyed_delete.f
rtl/core/fqkd_pkg.sv
rtl/core/fqkd_cell.sv
rtl/core/fifo_queue_with_keyed_delete.sv
sim/tb.sv
